>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks, trr_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define TRR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off while rst is high
`define TRR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/trr_pkg.sv
// Package: widths, register indexes and item types of the reshape index remap
package trr_pkg;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int VALUE_W    = 32;
  localparam int RANK_W     = 2;
  localparam int PLANE_W    = 2 * DIM_W;
  localparam int POS_W      = PLANE_W + COORD_W + 1;
  localparam int COUNT_W    = PLANE_W + DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam int MAX_DIM_DEFAULT     = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_RANK       = 3'd0,
    REG_TARGET_DIM_FIRST  = 3'd1,
    REG_TARGET_DIM_SECOND = 3'd2,
    REG_TARGET_DIM_THIRD  = 3'd3,
    REG_SOURCE_CHANNELS   = 3'd4,
    REG_SOURCE_ROWS       = 3'd5,
    REG_SOURCE_COLS       = 3'd6
  } reg_index_t;

  localparam logic [RANK_W-1:0] RANK_ONE   = 2'd1;
  localparam logic [RANK_W-1:0] RANK_TWO   = 2'd2;
  localparam logic [RANK_W-1:0] RANK_THREE = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] src_channel;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [VALUE_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] dst_channel;
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
    logic [VALUE_W-1:0] out_value;
    logic               shape_ok;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } pos_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0] src_plane;
    logic [DIM_W-1:0]   src_cols;
    logic [PLANE_W-1:0] plane;
    logic [DIM_W-1:0]   tcol;
    logic               zero;
    logic               ok;
  } shape_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/trr_ifs.sv
// Stream interfaces for source elements and remapped elements
interface trr_in_if;
  import trr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trr_out_if;
  import trr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/trr_shape.sv
// Configuration registers and shape values derived from them
module trr_shape import trr_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output shape_t                shape
);

  logic [RANK_W-1:0] rank;
  logic [DIM_W-1:0]  dim_first;
  logic [DIM_W-1:0]  dim_second;
  logic [DIM_W-1:0]  dim_third;
  logic [DIM_W-1:0]  src_channels;
  logic [DIM_W-1:0]  src_rows;
  logic [DIM_W-1:0]  src_cols;

  logic [DIM_W-1:0]  tch;
  logic [DIM_W-1:0]  trow;
  logic [DIM_W-1:0]  tcol;
  logic              tdims_ok;
  logic              sdims_ok;
  logic              zero;

  logic [PLANE_W-1:0] plane;
  logic [PLANE_W-1:0] src_plane;
  logic [DIM_W-1:0]   tch_q;
  logic [DIM_W-1:0]   sch_q;
  logic [DIM_W-1:0]   tcol_q;
  logic               dims_ok_q;
  logic               zero_q;

  logic [COUNT_W-1:0] tcount;
  logic [COUNT_W-1:0] scount;
  logic               dims_ok_q2;
  logic               zero_q2;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (32'(d) <= 32'(MAX_DIM));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rank         <= RANK_THREE;
      dim_first    <= DIM_W'(1);
      dim_second   <= DIM_W'(1);
      dim_third    <= DIM_W'(1);
      src_channels <= DIM_W'(1);
      src_rows     <= DIM_W'(1);
      src_cols     <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_RANK:       rank         <= cfg_wdata[RANK_W-1:0];
        REG_TARGET_DIM_FIRST:  dim_first    <= cfg_wdata;
        REG_TARGET_DIM_SECOND: dim_second   <= cfg_wdata;
        REG_TARGET_DIM_THIRD:  dim_third    <= cfg_wdata;
        REG_SOURCE_CHANNELS:   src_channels <= cfg_wdata;
        REG_SOURCE_ROWS:       src_rows     <= cfg_wdata;
        REG_SOURCE_COLS:       src_cols     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rank)
      RANK_THREE: begin
        tch      = dim_first;
        trow     = dim_second;
        tcol     = dim_third;
        tdims_ok = dim_ok(dim_first) && dim_ok(dim_second) && dim_ok(dim_third);
      end
      RANK_TWO: begin
        tch      = DIM_W'(1);
        trow     = dim_first;
        tcol     = dim_second;
        tdims_ok = dim_ok(dim_first) && dim_ok(dim_second);
      end
      RANK_ONE: begin
        tch      = DIM_W'(1);
        trow     = dim_first;
        tcol     = DIM_W'(1);
        tdims_ok = dim_ok(dim_first);
      end
      default: begin
        tch      = '0;
        trow     = '0;
        tcol     = '0;
        tdims_ok = 1'b0;
      end
    endcase
    sdims_ok = dim_ok(src_channels) && dim_ok(src_rows) && dim_ok(src_cols);
    zero     = (trow == '0) || (tcol == '0);
  end

  always_ff @(posedge clk) begin
    plane      <= trow * tcol;
    src_plane  <= src_rows * src_cols;
    tch_q      <= tch;
    sch_q      <= src_channels;
    tcol_q     <= tcol;
    dims_ok_q  <= tdims_ok && sdims_ok;
    zero_q     <= zero;
    tcount     <= tch_q * plane;
    scount     <= sch_q * src_plane;
    dims_ok_q2 <= dims_ok_q;
    zero_q2    <= zero_q;
  end

  assign shape.src_plane = src_plane;
  assign shape.src_cols  = src_cols;
  assign shape.plane     = plane;
  assign shape.tcol      = tcol_q;
  assign shape.zero      = zero_q;
  assign shape.ok        = dims_ok_q2 && !zero_q2 && (tcount == scount);

endmodule

>>> hw/rtl/trr_front.sv
// Front end: accept source elements and form their row-major position
module trr_front import trr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  trr_in_if.sink        src,
  input  shape_t        shape,
  input  queue_status_t status,
  output logic          push,
  output pos_item_t     push_item
);

  logic     a_valid;
  in_item_t a_item;

  logic                       b_valid;
  logic [PLANE_W+COORD_W-1:0] b_pa;
  logic [DIM_W+COORD_W-1:0]   b_pb;
  logic [COORD_W-1:0]         b_col;
  logic [VALUE_W-1:0]         b_value;

  logic b_adv;
  logic a_adv;

  assign b_adv     = !b_valid || !status.full;
  assign a_adv     = !a_valid || b_adv;
  assign src.ready = a_adv;
  assign push      = b_valid && !status.full;

  assign push_item.pos   = POS_W'(b_pa) + POS_W'(b_pb) + POS_W'(b_col);
  assign push_item.value = b_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= src.valid;
        a_item  <= src.data;
      end
      if (b_adv) begin
        b_valid <= a_valid;
        b_pa    <= a_item.src_channel * shape.src_plane;
        b_pb    <= a_item.src_row * shape.src_cols;
        b_col   <= a_item.src_col;
        b_value <= a_item.element_value;
      end
    end
  end

endmodule

>>> hw/rtl/trr_queue.sv
// Short register queue between the front end and the divider back end
`include "assert_macros.svh"

module trr_queue import trr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pos_item_t     push_item,
  input  logic          pop,
  output pos_item_t     head,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  pos_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr          <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TRR_ASSERT_IMP(a_no_overflow, push, !status.full)
  `TRR_ASSERT_IMP(a_no_underflow, pop, !status.empty)
  `TRR_ASSERT_NXT(a_count_up, push && !pop, count == CNT_W'($past(count) + 1'b1))

endmodule

>>> hw/rtl/trr_back.sv
// Back end: pipelined restoring dividers and the output register
module trr_back import trr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  pos_item_t     head,
  input  queue_status_t status,
  input  shape_t        shape,
  output logic          pop,
  trr_out_if.source     dst
);

  localparam int D1_STAGES = POS_W;
  localparam int D2_STAGES = PLANE_W - DIM_W;

  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   pos;
    logic [PLANE_W-1:0] r;
    logic [COORD_W-1:0] q;
    logic [VALUE_W-1:0] value;
  } d1_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] och;
    logic [DIM_W-1:0]   r;
    logic [D2_STAGES-1:0] dvd;
    logic [COORD_W-1:0] q;
    logic [VALUE_W-1:0] value;
  } d2_t;

  function automatic d1_t d1_step(input d1_t s, input logic [PLANE_W-1:0] divisor);
    logic [PLANE_W:0] t;
    d1_t              n;
    n     = s;
    t     = {s.r, s.pos[POS_W-1]};
    n.pos = {s.pos[POS_W-2:0], 1'b0};
    if (t >= {1'b0, divisor}) begin
      n.r = PLANE_W'(t - {1'b0, divisor});
      n.q = {s.q[COORD_W-2:0], 1'b1};
    end else begin
      n.r = t[PLANE_W-1:0];
      n.q = {s.q[COORD_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic d2_t d2_step(input d2_t s, input logic [DIM_W-1:0] divisor);
    logic [DIM_W:0] t;
    d2_t            n;
    n     = s;
    t     = {s.r, s.dvd[D2_STAGES-1]};
    n.dvd = {s.dvd[D2_STAGES-2:0], 1'b0};
    if (t >= {1'b0, divisor}) begin
      n.r = DIM_W'(t - {1'b0, divisor});
      n.q = {s.q[COORD_W-2:0], 1'b1};
    end else begin
      n.r = t[DIM_W-1:0];
      n.q = {s.q[COORD_W-2:0], 1'b0};
    end
    return n;
  endfunction

  logic en;
  d1_t  d1_head;
  d1_t  d1 [1:D1_STAGES];
  d2_t  d2_head;
  d2_t  d2 [1:D2_STAGES];

  assign en  = !dst.valid || dst.ready;
  assign pop = en && !status.empty;

  always_comb begin
    d1_head.valid = !status.empty;
    d1_head.pos   = head.pos;
    d1_head.r     = '0;
    d1_head.q     = '0;
    d1_head.value = head.value;
  end

  for (genvar k = 0; k < D1_STAGES; k++) begin : g_div1
    d1_t cur;
    if (k == 0) begin : g_first
      assign cur = d1_head;
    end else begin : g_next
      assign cur = d1[k];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d1[k+1].valid <= 1'b0;
      end else if (en) begin
        d1[k+1] <= d1_step(cur, shape.plane);
      end
    end
  end

  // quotient of the second split stays below the target row count
  always_comb begin
    d2_head.valid = d1[D1_STAGES].valid;
    d2_head.och   = d1[D1_STAGES].q;
    d2_head.r     = d1[D1_STAGES].r[PLANE_W-1:D2_STAGES];
    d2_head.dvd   = d1[D1_STAGES].r[D2_STAGES-1:0];
    d2_head.q     = '0;
    d2_head.value = d1[D1_STAGES].value;
  end

  for (genvar k = 0; k < D2_STAGES; k++) begin : g_div2
    d2_t cur;
    if (k == 0) begin : g_first
      assign cur = d2_head;
    end else begin : g_next
      assign cur = d2[k];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d2[k+1].valid <= 1'b0;
      end else if (en) begin
        d2[k+1] <= d2_step(cur, shape.tcol);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (en) begin
      dst.valid          <= d2[D2_STAGES].valid;
      dst.data.out_value <= d2[D2_STAGES].value;
      if (shape.zero) begin
        dst.data.dst_channel <= '0;
        dst.data.dst_row     <= '0;
        dst.data.dst_col     <= '0;
        dst.data.shape_ok    <= 1'b0;
      end else begin
        dst.data.dst_channel <= d2[D2_STAGES].och;
        dst.data.dst_row     <= d2[D2_STAGES].q;
        dst.data.dst_col     <= d2[D2_STAGES].r[COORD_W-1:0];
        dst.data.shape_ok    <= shape.ok;
      end
    end
  end

endmodule

>>> hw/rtl/tensor_reshape_index_remap.sv
// Top level: row-major reshape of tensor element coordinates
// Accepts one source element per cycle while the queue has room and returns
// one remapped element per element, in order. The front end's input register
// and product register form the linear position; then come the queue, 39
// restoring-divider stages (one quotient bit each) that split off the target
// plane, 13 stages that split the remainder by the target column count, and
// one output register. Output stalls freeze the divider pipeline; the front end
// keeps taking elements until the queue fills. Derived shape values are
// registered from the configuration registers. No clearing pass after reset.
module tensor_reshape_index_remap import trr_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  trr_in_if.sink                src,
  trr_out_if.source             dst
);

  shape_t        shape;
  queue_status_t status;
  logic          push;
  logic          pop;
  pos_item_t     push_item;
  pos_item_t     head;

  trr_shape #(.MAX_DIM(MAX_DIM)) u_shape (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .shape     (shape)
  );

  trr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src       (src),
    .shape     (shape),
    .status    (status),
    .push      (push),
    .push_item (push_item)
  );

  trr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  trr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .status (status),
    .shape  (shape),
    .pop    (pop),
    .dst    (dst)
  );

endmodule

>>> sim/testbench.sv
// Testbench: reshape index remap checked against a built-in predictor
`timescale 1ns / 1ps

module testbench import trr_pkg::*;;

  localparam int MAX_DIM          = MAX_DIM_DEFAULT;
  localparam int PIPE_LATENCY     = 56;
  localparam int CFG_SETTLE       = 5;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int ITEM_TARGET      = 850;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [RANK_W-1:0]    RANK_NONE  = 2'd0;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  trr_in_if  src_if ();
  trr_out_if dst_if ();

  tensor_reshape_index_remap #(
    .MAX_DIM     (MAX_DIM),
    .QUEUE_DEPTH (QUEUE_DEPTH_DEFAULT)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .src       (src_if),
    .dst       (dst_if)
  );

  logic [RANK_W-1:0] cfg_rank   = RANK_THREE;
  logic [DIM_W-1:0]  tgt_first  = 1;
  logic [DIM_W-1:0]  tgt_second = 1;
  logic [DIM_W-1:0]  tgt_third  = 1;
  logic [DIM_W-1:0]  src_chans  = 1;
  logic [DIM_W-1:0]  src_rows   = 1;
  logic [DIM_W-1:0]  src_cols   = 1;

  out_item_t pending_remaps [$];
  int        mismatches    = 0;
  int        items_sent    = 0;
  int        quiet_cycles  = 0;
  bit        idle_on       = 1'b1;
  bit        sink_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit dim_ok(input logic [DIM_W-1:0] d);
    return d >= 1 && d <= MAX_DIM;
  endfunction

  function automatic out_item_t remap_element(input in_item_t e);
    logic [63:0] tch, trow, tcol, pos, plane, rem;
    bit          ok;
    out_item_t   r;
    r = '0;
    r.out_value = e.element_value;
    case (cfg_rank)
      RANK_THREE: begin
        tch = tgt_first; trow = tgt_second; tcol = tgt_third;
        ok = dim_ok(tgt_first) && dim_ok(tgt_second) && dim_ok(tgt_third);
      end
      RANK_TWO: begin
        tch = 1; trow = tgt_first; tcol = tgt_second;
        ok = dim_ok(tgt_first) && dim_ok(tgt_second);
      end
      RANK_ONE: begin
        tch = 1; trow = tgt_first; tcol = 1;
        ok = dim_ok(tgt_first);
      end
      default: begin
        tch = 0; trow = 0; tcol = 0;
        ok = 1'b0;
      end
    endcase
    ok = ok && dim_ok(src_chans) && dim_ok(src_rows) && dim_ok(src_cols);
    ok = ok && (tch * trow * tcol == 64'(src_chans) * 64'(src_rows) * 64'(src_cols));
    if (cfg_rank != RANK_NONE && trow != 0 && tcol != 0) begin
      pos = 64'(e.src_channel) * 64'(src_rows) * 64'(src_cols)
          + 64'(e.src_row) * 64'(src_cols) + 64'(e.src_col);
      plane = trow * tcol;
      rem = pos % plane;
      r.dst_channel = 12'(pos / plane);
      r.dst_row     = 12'(rem / tcol);
      r.dst_col     = 12'(rem % tcol);
    end else begin
      ok = 1'b0;
    end
    r.shape_ok = ok;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic in_item_t make_element();
    in_item_t e;
    e.element_value = $urandom;
    if ($urandom_range(0, 99) < 85 && dim_ok(src_chans) && dim_ok(src_rows)
        && dim_ok(src_cols)) begin
      e.src_channel = 12'($urandom_range(0, src_chans - 1));
      e.src_row     = 12'($urandom_range(0, src_rows - 1));
      e.src_col     = 12'($urandom_range(0, src_cols - 1));
    end else begin
      e.src_channel = 12'($urandom);
      e.src_row     = 12'($urandom);
      e.src_col     = 12'($urandom);
    end
    return e;
  endfunction

  task automatic send_element(input in_item_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_if.valid <= 1'b1;
    src_if.data  <= item;
    do @(posedge clk); while (!src_if.ready);
    pending_remaps.push_back(remap_element(item));
    items_sent++;
  endtask

  task automatic drain_and_pause();
    src_if.valid <= 1'b0;
    while (pending_remaps.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  task automatic program_shape(input logic [DIM_W-1:0] rank_word,
                               input logic [DIM_W-1:0] t1, t2, t3, s1, s2, s3);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [DIM_W-1:0]     val [8];
    drain_and_pause();
    idx = '{REG_TARGET_RANK, REG_TARGET_DIM_FIRST, REG_TARGET_DIM_SECOND,
            REG_TARGET_DIM_THIRD, REG_SOURCE_CHANNELS, REG_SOURCE_ROWS,
            REG_SOURCE_COLS, REG_UNUSED};
    val = '{rank_word, t1, t2, t3, s1, s2, s3, 13'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_rank   = rank_word[RANK_W-1:0];
    tgt_first  = t1;
    tgt_second = t2;
    tgt_third  = t3;
    src_chans  = s1;
    src_rows   = s2;
    src_cols   = s3;
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && dst_if.valid && dst_if.ready) begin
      if (pending_remaps.size() == 0) begin
        $display("%0t: remapped element with none expected, got %p", $time, dst_if.data);
        mismatches++;
      end else begin
        want = pending_remaps.pop_front();
        check_field("dst_channel", 32'(want.dst_channel), 32'(dst_if.data.dst_channel));
        check_field("dst_row", 32'(want.dst_row), 32'(dst_if.data.dst_row));
        check_field("dst_col", 32'(want.dst_col), 32'(dst_if.data.dst_col));
        check_field("out_value", want.out_value, dst_if.data.out_value);
        check_field("shape_ok", 32'(want.shape_ok), 32'(dst_if.data.shape_ok));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int stall;
    dst_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        dst_if.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        dst_if.ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          dst_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        dst_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    send_element(in_item_t'{12'd0, 12'd0, 12'd0, 32'h0});
    send_element(in_item_t'{12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF});
  endtask

  task automatic test_directed_shapes();
    program_shape(RANK_THREE, 4096, 4096, 4096, 4096, 4096, 4096);
    send_element(in_item_t'{12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF});
    send_element(in_item_t'{12'd0, 12'd0, 12'd0, 32'h0});
    // rank with stray upper bits in the write data
    program_shape({11'h7FF, RANK_TWO}, 64, 4096, 1, 16, 16, 1024);
    send_element(in_item_t'{12'd15, 12'd15, 12'd1023, $urandom});
    send_element(in_item_t'{12'd7, 12'd3, 12'd512, $urandom});
    program_shape(RANK_ONE, 4096, 0, 8191, 16, 16, 16);
    send_element(in_item_t'{12'd15, 12'd15, 12'd15, $urandom});
    send_element(in_item_t'{12'd0, 12'd0, 12'd1, $urandom});
    program_shape({11'h7FF, RANK_NONE}, 4, 4, 4, 4, 4, 4);
    send_element(in_item_t'{12'd1, 12'd2, 12'd3, $urandom});
    program_shape(RANK_THREE, 2, 0, 8, 2, 2, 4);
    send_element(in_item_t'{12'd1, 12'd1, 12'd3, $urandom});
    program_shape(RANK_THREE, 0, 4, 4, 2, 2, 4);
    send_element(in_item_t'{12'd1, 12'd1, 12'd3, $urandom});
    program_shape(RANK_THREE, 1, 1, 8191, 1, 1, 8191);
    send_element(in_item_t'{12'd0, 12'd0, 12'd4095, $urandom});
    send_element(in_item_t'{12'd3, 12'd2, 12'd100, $urandom});
    program_shape(RANK_TWO, 4097, 3, 1, 1, 4097, 3);
    send_element(in_item_t'{12'd0, 12'd4000, 12'd2, $urandom});
    program_shape(RANK_THREE, 2, 3, 5, 2, 3, 4);
    send_element(in_item_t'{12'd1, 12'd2, 12'd3, $urandom});
    send_element(in_item_t'{12'd1, 12'd2, 12'd4095, $urandom});
    program_shape(RANK_TWO, 4, 4, 1, 1, 0, 16);
    send_element(in_item_t'{12'd5, 12'd5, 12'd9, $urandom});
  endtask

  task automatic test_output_backpressure();
    program_shape(RANK_THREE, 8, 16, 32, 16, 32, 8);
    idle_on = 1'b0;
    // hold ready low so the pipeline backs up into the input
    sink_hold_req = 1'b1;
    repeat (120) send_element(make_element());
    idle_on = 1'b1;
  endtask

  task automatic test_random_reshapes();
    int unsigned x [6];
    int unsigned a, b, c;
    int          kind;
    while (items_sent < ITEM_TARGET) begin
      foreach (x[i]) x[i] = $urandom_range(1, 64);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: program_shape(RANK_THREE, 13'(x[0] * x[2]), 13'(x[1] * x[4]),
                                  13'(x[3] * x[5]), 13'(x[0] * x[1]),
                                  13'(x[2] * x[3]), 13'(x[4] * x[5]));
        4, 5: program_shape(RANK_TWO, 13'(x[0] * x[1]), 13'(x[2] * x[3]),
                            13'($urandom), 13'(x[0]), 13'(x[1] * x[2]), 13'(x[3]));
        6: begin
          a = $urandom_range(1, 16);
          b = $urandom_range(1, 16);
          c = $urandom_range(1, 16);
          program_shape(RANK_ONE, 13'(a * b * c), 13'($urandom), 13'($urandom),
                        13'(a), 13'(b), 13'(c));
        end
        7: begin
          a = $urandom_range(0, 1) ? MAX_DIM : 1;
          b = $urandom_range(0, 1) ? MAX_DIM : 1;
          c = $urandom_range(0, 1) ? MAX_DIM : 1;
          program_shape(RANK_THREE, 13'(c), 13'(a), 13'(b), 13'(a), 13'(b), 13'(c));
        end
        8: program_shape(13'($urandom_range(1, 3)), 13'($urandom_range(1, MAX_DIM)),
                         13'($urandom_range(1, MAX_DIM)), 13'($urandom_range(1, MAX_DIM)),
                         13'($urandom_range(1, MAX_DIM)), 13'($urandom_range(1, MAX_DIM)),
                         13'($urandom_range(1, MAX_DIM)));
        default: program_shape(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
                               13'($urandom), 13'($urandom), 13'($urandom));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(15, 60)) send_element(make_element());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_TARGET_RANK;
    cfg_wdata    <= '0;
    src_if.valid <= 1'b0;
    src_if.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_shapes();
    test_output_backpressure();
    test_random_reshapes();
    drain_and_pause();
    if (mismatches == 0 && pending_remaps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
